// ----- rtl/core/mce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mce_pkg
// Shared types and constants for the CP0 exception unit: command codes,
// register numbers, exception vectors and the request/response structs.
// ----------------------------------------------------------------------------
package mce_pkg;

    // Command codes.
    localparam logic [1:0] CMD_ACCESS = 2'd0;
    localparam logic [1:0] CMD_TRAP   = 2'd1;
    localparam logic [1:0] CMD_ERET   = 2'd2;
    localparam logic [1:0] CMD_INTR   = 2'd3;

    // Supported CP0 register numbers.
    localparam logic [4:0] REG_INDEX    = 5'd0;
    localparam logic [4:0] REG_ENTRYLO0 = 5'd2;
    localparam logic [4:0] REG_ENTRYLO1 = 5'd3;
    localparam logic [4:0] REG_ENTRYHI  = 5'd10;
    localparam logic [4:0] REG_STATUS   = 5'd12;
    localparam logic [4:0] REG_CAUSE    = 5'd13;
    localparam logic [4:0] REG_EPC      = 5'd14;

    // Exception vectors and register masks.
    localparam logic [31:0] VEC_GENERAL   = 32'h8000_0180;
    localparam logic [31:0] VEC_REFILL    = 32'h8000_0000;
    localparam logic [31:0] ENTRYHI_CLEAR = 32'h0000_1f00;

    // Status bit positions.
    localparam int ST_IE_BIT  = 0;
    localparam int ST_EXL_BIT = 1;

    // One input transaction.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  code;
        logic        refill_trap;
        logic        rd_en;
        logic        wr_en;
        logic [31:0] operand;
        logic        intr_pending;
    } t_req;

    // One result transaction.
    typedef struct packed {
        logic [31:0] result_value;
        logic        intr_taken;
        logic        bad_reg;
    } t_result;

endpackage

// ----- rtl/core/mce_regfile.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mce_regfile
// CP0 register state with the per-command update logic. The result of a
// request is formed combinationally from the current state; state updates
// at the edge where the request fires.
// ----------------------------------------------------------------------------
module mce_regfile (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  mce_pkg::t_req     i_req,
    output mce_pkg::t_result  o_res
);

    logic [31:0] r_index, n_index;
    logic [31:0] r_lo0, n_lo0;
    logic [31:0] r_lo1, n_lo1;
    logic [31:0] r_hi, n_hi;
    logic [31:0] r_status, n_status;
    logic [31:0] r_cause, n_cause;
    logic [31:0] r_epc, n_epc;

    logic        sel_ok;
    logic [31:0] sel_val;
    logic        intr_go;

    // Register select for an access.
    always_comb begin
        sel_ok  = 1'b1;
        sel_val = 32'd0;
        case (i_req.code)
            mce_pkg::REG_INDEX:    sel_val = r_index;
            mce_pkg::REG_ENTRYLO0: sel_val = r_lo0;
            mce_pkg::REG_ENTRYLO1: sel_val = r_lo1;
            mce_pkg::REG_ENTRYHI:  sel_val = r_hi;
            mce_pkg::REG_STATUS:   sel_val = r_status;
            mce_pkg::REG_CAUSE:    sel_val = r_cause;
            mce_pkg::REG_EPC:      sel_val = r_epc;
            default:               sel_ok  = 1'b0;
        endcase
    end

    assign intr_go = i_req.intr_pending && r_status[mce_pkg::ST_IE_BIT]
                     && !r_status[mce_pkg::ST_EXL_BIT];

    // Result and next state for the current request.
    always_comb begin
        n_index  = r_index;
        n_lo0    = r_lo0;
        n_lo1    = r_lo1;
        n_hi     = r_hi;
        n_status = r_status;
        n_cause  = r_cause;
        n_epc    = r_epc;
        o_res    = '0;
        case (i_req.cmd)
            mce_pkg::CMD_ACCESS: begin
                if (!sel_ok) begin
                    o_res.bad_reg = 1'b1;
                end else begin
                    if (i_req.rd_en) begin
                        o_res.result_value = sel_val;
                    end
                    if (i_req.wr_en) begin
                        case (i_req.code)
                            mce_pkg::REG_INDEX:    n_index  = i_req.operand;
                            mce_pkg::REG_ENTRYLO0: n_lo0    = i_req.operand;
                            mce_pkg::REG_ENTRYLO1: n_lo1    = i_req.operand;
                            mce_pkg::REG_ENTRYHI:  n_hi     = i_req.operand
                                                              & ~mce_pkg::ENTRYHI_CLEAR;
                            mce_pkg::REG_STATUS:   n_status = i_req.operand;
                            mce_pkg::REG_CAUSE:    n_cause  = i_req.operand;
                            mce_pkg::REG_EPC:      n_epc    = i_req.operand;
                            default:               n_index  = r_index;
                        endcase
                    end
                end
            end
            mce_pkg::CMD_TRAP: begin
                n_cause  = {25'd0, i_req.code, 2'b00};
                n_epc    = i_req.operand;
                n_status[mce_pkg::ST_EXL_BIT] = 1'b1;
                o_res.result_value = i_req.refill_trap ? mce_pkg::VEC_REFILL
                                                       : mce_pkg::VEC_GENERAL;
            end
            mce_pkg::CMD_ERET: begin
                n_status[mce_pkg::ST_EXL_BIT] = 1'b0;
                o_res.result_value = r_epc;
            end
            default: begin
                // Interrupt check: taken as a trap with code zero.
                if (intr_go) begin
                    n_cause  = 32'd0;
                    n_epc    = i_req.operand;
                    n_status[mce_pkg::ST_EXL_BIT] = 1'b1;
                    o_res.result_value = mce_pkg::VEC_GENERAL;
                    o_res.intr_taken   = 1'b1;
                end
            end
        endcase
    end

    // State registers, updated only when a transaction fires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index  <= '0;
            r_lo0    <= '0;
            r_lo1    <= '0;
            r_hi     <= '0;
            r_status <= '0;
            r_cause  <= '0;
            r_epc    <= '0;
        end else if (i_fire) begin
            r_index  <= n_index;
            r_lo0    <= n_lo0;
            r_lo1    <= n_lo1;
            r_hi     <= n_hi;
            r_status <= n_status;
            r_cause  <= n_cause;
            r_epc    <= n_epc;
        end
    end

    // A trap always leaves EXL set.
    a_trap_sets_exl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.cmd == mce_pkg::CMD_TRAP) |=> r_status[mce_pkg::ST_EXL_BIT])
        else $error("trap did not set status.EXL");

    // An exception return always clears EXL.
    a_eret_clears_exl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.cmd == mce_pkg::CMD_ERET) |=> !r_status[mce_pkg::ST_EXL_BIT])
        else $error("eret did not clear status.EXL");

    // An unsupported register number leaves every register unchanged.
    a_bad_reg_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && o_res.bad_reg) |=> ($stable(r_index) && $stable(r_lo0)
        && $stable(r_lo1) && $stable(r_hi) && $stable(r_status)
        && $stable(r_cause) && $stable(r_epc)))
        else $error("bad register access changed state");

    // Entryhi never holds bits 12..8.
    a_entryhi_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hi & mce_pkg::ENTRYHI_CLEAR) == 32'd0)
        else $error("entryhi holds cleared bits");

endmodule

// ----- rtl/core/mips_cp0_exception_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_cp0_exception_unit
// Reduced MIPS32 CP0 unit: register access, trap entry, exception return
// and interrupt check, with a registered result and a skid stage.
//
// Channel  Handshake                  Fields
// input    i_in_valid / o_in_stall    cmd, code, refill_trap, rd_en, wr_en, operand, intr_pending
// output   o_out_valid / i_out_stall  result_value, intr_taken, bad_reg
//
// One transaction per cycle while o_in_stall is low; each result is registered.
// The CP0 state updates at the accepting edge, so back-to-back transactions
// see each other's effects with no bubbles.
// When the output stalls, one more transaction is taken into the skid stage;
// o_in_stall rises only while that stage is full.
// Reset clears all CP0 registers and empties the output and skid stages.
// ----------------------------------------------------------------------------
module mips_cp0_exception_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [4:0]  i_code,
    input  logic        i_refill_trap,
    input  logic        i_rd_en,
    input  logic        i_wr_en,
    input  logic [31:0] i_operand,
    input  logic        i_intr_pending,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_result_value,
    output logic        o_intr_taken,
    output logic        o_bad_reg
);

    mce_pkg::t_req    req;
    mce_pkg::t_result res;
    mce_pkg::t_result r_out;
    mce_pkg::t_result r_skid;
    logic             r_out_valid;
    logic             r_skid_valid;
    logic             fire;
    logic             out_take;

    // Pack the input fields.
    assign req.cmd          = i_cmd;
    assign req.code         = i_code;
    assign req.refill_trap  = i_refill_trap;
    assign req.rd_en        = i_rd_en;
    assign req.wr_en        = i_wr_en;
    assign req.operand      = i_operand;
    assign req.intr_pending = i_intr_pending;

    assign o_in_stall = r_skid_valid;
    assign fire       = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    mce_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (req),
        .o_res   (res)
    );

    // Output register and skid stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_skid_valid <= 1'b0;
                end
            end else if (fire) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output and skid payload.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (fire) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out.result_value;
    assign o_intr_taken   = r_out.intr_taken;
    assign o_bad_reg      = r_out.bad_reg;

    // The skid stage only holds a transaction behind a waiting output.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full with empty output register");

    // A stalled output with a full skid keeps both stages occupied.
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> (r_skid_valid && r_out_valid))
        else $error("skid transaction lost under stall");

    // An accepted transaction always leaves the output register valid next cycle.
    a_fire_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("accepted transaction missing from output");

endmodule

// ----- tb/mips_cp0_exception_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_cp0_exception_unit_test
// Self-checking bench for the CP0 exception unit. Each accepted transaction
// runs through a local copy of the CP0 registers, and the predicted result is
// queued. Every returned result is compared field by field, in order, with
// the oldest queued prediction. Directed register and exception sequences are
// followed by random traffic with random gaps, a stretch at full rate, and
// long output hold-offs that fill the unit and stall its input.
// ----------------------------------------------------------------------------
module mips_cp0_exception_unit_test;

    localparam int IDLE_PCT       = 23;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_LIMIT    = 50;

    // Clock, reset and block inputs, all known from time zero.
    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            out_stall = 1'b0;
    mce_pkg::t_req   drv       = '0;

    // Block outputs.
    logic        in_stall;
    logic        out_valid;
    logic [31:0] res_value;
    logic        res_taken;
    logic        res_bad;

    // Local copy of the CP0 registers.
    logic [31:0] cp0_index   = '0;
    logic [31:0] cp0_lo0     = '0;
    logic [31:0] cp0_lo1     = '0;
    logic [31:0] cp0_entryhi = '0;
    logic [31:0] cp0_status  = '0;
    logic [31:0] cp0_cause   = '0;
    logic [31:0] cp0_epc     = '0;

    // Predicted results waiting for the block to return them.
    mce_pkg::t_result cp0_results_due[$];

    // Supported register numbers, for biasing random accesses.
    logic [4:0]  cp0_reg_nums[7] = '{mce_pkg::REG_INDEX, mce_pkg::REG_ENTRYLO0,
                                     mce_pkg::REG_ENTRYLO1, mce_pkg::REG_ENTRYHI,
                                     mce_pkg::REG_STATUS, mce_pkg::REG_CAUSE,
                                     mce_pkg::REG_EPC};

    int          mismatches  = 0;
    int          idle_cycles = 0;
    bit          no_gaps     = 1'b0;
    int unsigned hold_budget = 0;
    int unsigned hold_done   = 0;

    mips_cp0_exception_unit u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd          (drv.cmd),
        .i_code         (drv.code),
        .i_refill_trap  (drv.refill_trap),
        .i_rd_en        (drv.rd_en),
        .i_wr_en        (drv.wr_en),
        .i_operand      (drv.operand),
        .i_intr_pending (drv.intr_pending),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_value (res_value),
        .o_intr_taken   (res_taken),
        .o_bad_reg      (res_bad)
    );

    // 20 ns clock.
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Exception entry: cause gets the code, epc the pc, and EXL is set.
    function automatic logic [31:0] enter_exception(input logic [4:0] exc_code,
                                                    input logic refill,
                                                    input logic [31:0] pc);
        cp0_cause = {25'd0, exc_code, 2'b00};
        cp0_epc = pc;
        cp0_status[mce_pkg::ST_EXL_BIT] = 1'b1;
        return refill ? mce_pkg::VEC_REFILL : mce_pkg::VEC_GENERAL;
    endfunction

    // Applies one transaction to the local CP0 copy and returns its result.
    function automatic mce_pkg::t_result cp0_apply(input mce_pkg::t_req req);
        mce_pkg::t_result res;
        logic [31:0]      old;
        res = '0;
        old = '0;
        case (req.cmd)
            mce_pkg::CMD_ACCESS: begin
                case (req.code)
                    mce_pkg::REG_INDEX:    old = cp0_index;
                    mce_pkg::REG_ENTRYLO0: old = cp0_lo0;
                    mce_pkg::REG_ENTRYLO1: old = cp0_lo1;
                    mce_pkg::REG_ENTRYHI:  old = cp0_entryhi;
                    mce_pkg::REG_STATUS:   old = cp0_status;
                    mce_pkg::REG_CAUSE:    old = cp0_cause;
                    mce_pkg::REG_EPC:      old = cp0_epc;
                    default:               res.bad_reg = 1'b1;
                endcase
                if (!res.bad_reg && req.rd_en) begin
                    res.result_value = old;
                end
                if (!res.bad_reg && req.wr_en) begin
                    case (req.code)
                        mce_pkg::REG_INDEX:    cp0_index = req.operand;
                        mce_pkg::REG_ENTRYLO0: cp0_lo0 = req.operand;
                        mce_pkg::REG_ENTRYLO1: cp0_lo1 = req.operand;
                        mce_pkg::REG_ENTRYHI:
                            cp0_entryhi = req.operand & ~mce_pkg::ENTRYHI_CLEAR;
                        mce_pkg::REG_STATUS:   cp0_status = req.operand;
                        mce_pkg::REG_CAUSE:    cp0_cause = req.operand;
                        mce_pkg::REG_EPC:      cp0_epc = req.operand;
                        default:               ;
                    endcase
                end
            end
            mce_pkg::CMD_TRAP: begin
                res.result_value = enter_exception(req.code, req.refill_trap,
                                                   req.operand);
            end
            mce_pkg::CMD_ERET: begin
                cp0_status[mce_pkg::ST_EXL_BIT] = 1'b0;
                res.result_value = cp0_epc;
            end
            default: begin
                // The interrupt is taken only when enabled and not already in
                // exception level.
                if (req.intr_pending && cp0_status[mce_pkg::ST_IE_BIT]
                    && !cp0_status[mce_pkg::ST_EXL_BIT]) begin
                    res.result_value = enter_exception(5'd0, 1'b0, req.operand);
                    res.intr_taken = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PRINT_LIMIT) begin
            $display("ERROR at %0t ns: %s got %h, want %h", $time, field, got, want);
        end
        mismatches++;
    endtask

    // Offers one transaction, holds it until accepted, then records the
    // predicted result. Valid is left high; the next call lowers it if needed.
    task automatic send_op(input logic [1:0] cmd, input logic [4:0] code,
                           input logic refill, input logic rd, input logic wr,
                           input logic [31:0] operand, input logic pending);
        mce_pkg::t_req req;
        req.cmd = cmd;
        req.code = code;
        req.refill_trap = refill;
        req.rd_en = rd;
        req.wr_en = wr;
        req.operand = operand;
        req.intr_pending = pending;
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        drv <= req;
        @(posedge clk);
        while (in_stall !== 1'b0) begin
            @(posedge clk);
        end
        cp0_results_due.push_back(cp0_apply(req));
    endtask

    // One random transaction; accesses favor the supported registers.
    task automatic send_random_op();
        int unsigned pick;
        logic [1:0]  cmd;
        logic [4:0]  code;
        logic [31:0] operand;
        pick = $urandom_range(99);
        if (pick < 45) begin
            cmd = mce_pkg::CMD_ACCESS;
        end else if (pick < 60) begin
            cmd = mce_pkg::CMD_TRAP;
        end else if (pick < 80) begin
            cmd = mce_pkg::CMD_ERET;
        end else begin
            cmd = mce_pkg::CMD_INTR;
        end
        if (cmd == mce_pkg::CMD_ACCESS && $urandom_range(3) != 0) begin
            code = cp0_reg_nums[$urandom_range(6)];
        end else begin
            code = 5'($urandom_range(31));
        end
        case ($urandom_range(7))
            0:       operand = '0;
            1:       operand = '1;
            default: operand = $urandom;
        endcase
        send_op(cmd, code, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)), operand, 1'($urandom_range(1)));
    endtask

    // Register reads and writes, including entryhi masking and bad numbers.
    task automatic test_register_access();
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_INDEX,
                1'b0, 1'b1, 1'b0, 32'h0, 1'b0);
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_INDEX,
                1'b1, 1'b0, 1'b1, 32'hffff_ffff, 1'b1);
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_INDEX,
                1'b0, 1'b1, 1'b1, 32'h0, 1'b0);
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_ENTRYHI,
                1'b0, 1'b1, 1'b1, 32'hffff_ffff, 1'b0);
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_ENTRYHI,
                1'b0, 1'b1, 1'b0, 32'h0, 1'b0);
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_ENTRYLO0,
                1'b0, 1'b1, 1'b1, 32'hffff_ffff, 1'b0);
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_ENTRYLO1,
                1'b0, 1'b1, 1'b1, 32'ha5a5_a5a5, 1'b0);
        // No read and no write leaves cause alone.
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_CAUSE,
                1'b0, 1'b0, 1'b0, 32'hffff_ffff, 1'b0);
        // Unsupported numbers flag an error with or without enables.
        send_op(mce_pkg::CMD_ACCESS, 5'd31,
                1'b1, 1'b1, 1'b1, 32'hffff_ffff, 1'b1);
        send_op(mce_pkg::CMD_ACCESS, 5'd1,
                1'b0, 1'b0, 1'b0, 32'h0, 1'b0);
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_ENTRYLO1,
                1'b0, 1'b1, 1'b0, 32'h0, 1'b0);
    endtask

    // Interrupt gating, trap vectors and exception return.
    task automatic test_exception_flow();
        send_op(mce_pkg::CMD_INTR, 5'd0,
                1'b0, 1'b0, 1'b0, 32'h0000_1000, 1'b1);
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_STATUS,
                1'b0, 1'b1, 1'b1, 32'h0000_0001, 1'b0);
        send_op(mce_pkg::CMD_INTR, 5'd7,
                1'b1, 1'b1, 1'b1, 32'hbfc0_0040, 1'b1);
        send_op(mce_pkg::CMD_INTR, 5'd0,
                1'b0, 1'b0, 1'b0, 32'h1234_5678, 1'b1);
        send_op(mce_pkg::CMD_ERET, 5'd0,
                1'b0, 1'b0, 1'b0, 32'h0, 1'b0);
        send_op(mce_pkg::CMD_INTR, 5'd0,
                1'b0, 1'b0, 1'b0, 32'hffff_ffff, 1'b0);
        send_op(mce_pkg::CMD_TRAP, 5'd31,
                1'b1, 1'b0, 1'b0, 32'hffff_fffc, 1'b0);
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_CAUSE,
                1'b0, 1'b1, 1'b0, 32'h0, 1'b0);
        send_op(mce_pkg::CMD_TRAP, 5'd0,
                1'b0, 1'b1, 1'b1, 32'h0, 1'b1);
        // Exception return ignores every other field.
        send_op(mce_pkg::CMD_ERET, 5'd31,
                1'b1, 1'b1, 1'b1, 32'hffff_ffff, 1'b1);
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_STATUS,
                1'b0, 1'b1, 1'b0, 32'h0, 1'b0);
        send_op(mce_pkg::CMD_ACCESS, mce_pkg::REG_EPC,
                1'b0, 1'b1, 1'b1, 32'hffff_ffff, 1'b0);
    endtask

    // Random traffic with random gaps on both sides.
    task automatic test_random_traffic();
        repeat (650) send_random_op();
    endtask

    // Random traffic with no gaps at all, one transaction per cycle.
    task automatic test_full_rate();
        no_gaps = 1'b1;
        repeat (300) send_random_op();
        no_gaps = 1'b0;
    endtask

    // Long output hold-offs while the sender keeps offering transactions.
    task automatic test_output_backpressure();
        no_gaps = 1'b1;
        hold_budget <= hold_budget + 80;
        repeat (60) send_random_op();
        no_gaps = 1'b0;
        repeat (80) send_random_op();
        no_gaps = 1'b1;
        hold_budget <= hold_budget + 40;
        repeat (60) send_random_op();
        no_gaps = 1'b0;
    endtask

    // Output stall: requested hold-offs first, then random or none.
    always @(posedge clk) begin
        if (hold_done < hold_budget) begin
            out_stall <= 1'b1;
            hold_done <= hold_done + 1;
        end else if (no_gaps) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Result check against the oldest prediction.
    always @(posedge clk) begin : result_check
        mce_pkg::t_result due;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (cp0_results_due.size() == 0) begin
                report_mismatch("unexpected result_value", res_value, 32'h0);
            end else begin
                due = cp0_results_due.pop_front();
                if (res_value !== due.result_value) begin
                    report_mismatch("result_value", res_value, due.result_value);
                end
                if (res_taken !== due.intr_taken) begin
                    report_mismatch("intr_taken", 32'(res_taken), 32'(due.intr_taken));
                end
                if (res_bad !== due.bad_reg) begin
                    report_mismatch("bad_reg", 32'(res_bad), 32'(due.bad_reg));
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("mips_cp0_exception_unit verification failed");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_register_access();
        test_exception_flow();
        test_random_traffic();
        test_full_rate();
        test_output_backpressure();
        in_valid <= 1'b0;
        while (cp0_results_due.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (mismatches == 0) begin
            $display("mips_cp0_exception_unit verification clean");
        end else begin
            $display("mips_cp0_exception_unit verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/mce_pkg.sv
rtl/core/mce_regfile.sv
rtl/core/mips_cp0_exception_unit.sv
tb/mips_cp0_exception_unit_test.sv
